### rtl/lprd_pkg.sv
// Shared types and constants for the length-prefixed request deframer.
// No dependencies; used by lprd_step and length_prefixed_request_deframer.
`default_nettype none

package lprd_pkg;

    localparam int BODY_W  = 24;
    localparam int ARG_W   = 16;
    localparam int SHIFT_W = 24;  // three earlier header bytes; the fourth is the live byte

    // configuration register indexes
    localparam logic CFG_MAX_BODY = 1'b0;
    localparam logic CFG_MAX_ARGS = 1'b1;

    localparam logic [BODY_W-1:0] MAX_BODY_RESET = 24'd4096;
    localparam logic [ARG_W-1:0]  MAX_ARGS_RESET = 16'd1024;

    typedef enum logic [3:0] {
        PH_LEN    = 4'b0001,
        PH_ARGC   = 4'b0010,
        PH_ARGLEN = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        CMD_UNKNOWN = 2'd0,
        CMD_GET     = 2'd1,
        CMD_SET     = 2'd2,
        CMD_DEL     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_MALFORM  = 2'd2
    } err_t;

    // match flag bits
    localparam int M_GET = 0;
    localparam int M_SET = 1;
    localparam int M_DEL = 2;

    typedef struct packed {
        phase_t              phase;
        logic [1:0]          hdr_cnt;
        logic [SHIFT_W-1:0]  hdr_shift;
        logic [BODY_W-1:0]   body_rem;
        logic [ARG_W-1:0]    args_rem;
        logic [BODY_W-1:0]   arg_bytes_rem;
        logic [ARG_W-1:0]    cur_arg;
        logic [ARG_W-1:0]    total_args;
        logic [2:0]          match;
        logic                halt;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_LEN,
        hdr_cnt:       2'd0,
        hdr_shift:     '0,
        body_rem:      '0,
        args_rem:      '0,
        arg_bytes_rem: '0,
        cur_arg:       '0,
        total_args:    '0,
        match:         3'b111,
        halt:          1'b0
    };

    typedef struct packed {
        logic               data_valid;
        logic [7:0]         data_byte;
        logic [ARG_W-1:0]   arg_index;
        logic               arg_end;
        logic               frame_done;
        logic [ARG_W-1:0]   arg_count;
        cmd_t               command;
        err_t               error_code;
        logic               halted;
    } result_t;

endpackage

`default_nettype wire

### rtl/lprd_step.sv
// Per-byte parse step: next parser state and the result for one stream byte.
// Pure combinational; uses lprd_pkg.
`default_nettype none

module lprd_step (
    input  wire logic [7:0]                   in_byte,
    input  wire lprd_pkg::state_t             state,
    input  wire logic [lprd_pkg::BODY_W-1:0]  max_body_length,
    input  wire logic [lprd_pkg::ARG_W-1:0]   max_arguments,
    output lprd_pkg::state_t                  state_next,
    output lprd_pkg::result_t                 result
);

    // command name letters, lower case
    function automatic logic [7:0] cmd_char(input int k, input logic [1:0] pos);
        logic [23:0] name;
        begin
            case (k)
                lprd_pkg::M_GET: name = "get";
                lprd_pkg::M_SET: name = "set";
                default:         name = "del";
            endcase
            case (pos)
                2'd0:    cmd_char = name[23:16];
                2'd1:    cmd_char = name[15:8];
                default: cmd_char = name[7:0];
            endcase
        end
    endfunction

    function automatic lprd_pkg::cmd_t classify(input logic [lprd_pkg::ARG_W-1:0] n,
                                                input logic [2:0] m);
        begin
            if (n == 16'd2 && m[lprd_pkg::M_GET])
                classify = lprd_pkg::CMD_GET;
            else if (n == 16'd3 && m[lprd_pkg::M_SET])
                classify = lprd_pkg::CMD_SET;
            else if (n == 16'd2 && m[lprd_pkg::M_DEL])
                classify = lprd_pkg::CMD_DEL;
            else
                classify = lprd_pkg::CMD_UNKNOWN;
        end
    endfunction

    always_comb
    begin
        lprd_pkg::state_t  ns;
        lprd_pkg::result_t r;
        lprd_pkg::err_t    err;
        logic [31:0]       v;
        logic [7:0]        lc;
        logic [1:0]        pos;
        logic              fin;
        logic              sect;

        ns   = state;
        r    = '0;
        err  = lprd_pkg::ERR_NONE;
        fin  = 1'b0;
        sect = 1'b0;
        v    = {in_byte, state.hdr_shift};
        lc   = (in_byte inside {[8'h41:8'h5A]}) ? in_byte + 8'd32 : in_byte;
        pos  = 2'd3 - state.arg_bytes_rem[1:0];

        if (state.halt)
        begin
            r.halted = 1'b1;
        end
        else
        begin
            if (state.phase != lprd_pkg::PH_LEN)
                ns.body_rem = state.body_rem - 24'd1;

            if (state.phase == lprd_pkg::PH_DATA)
            begin
                r.data_valid = 1'b1;
                r.data_byte  = in_byte;
                r.arg_index  = state.cur_arg;
                if (state.cur_arg == '0 && state.arg_bytes_rem >= 24'd1
                    && state.arg_bytes_rem <= 24'd3)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (cmd_char(k, pos) != lc)
                            ns.match[k] = 1'b0;
                    end
                end
                ns.arg_bytes_rem = state.arg_bytes_rem - 24'd1;
                fin = (ns.arg_bytes_rem == '0);
            end
            else
            begin
                // little-endian header: new byte enters at the top
                ns.hdr_shift = {in_byte, state.hdr_shift[23:8]};
                ns.hdr_cnt   = state.hdr_cnt + 2'd1;
                if (state.hdr_cnt == 2'd3)
                begin
                    case (state.phase)
                        lprd_pkg::PH_LEN:
                        begin
                            if (v > {8'd0, max_body_length})
                                err = lprd_pkg::ERR_TOO_LONG;
                            else if (v < 32'd4)
                                err = lprd_pkg::ERR_MALFORM;
                            else
                            begin
                                ns.body_rem = v[23:0];
                                ns.match    = 3'b111;
                                ns.phase    = lprd_pkg::PH_ARGC;
                            end
                        end
                        lprd_pkg::PH_ARGC:
                        begin
                            if (v > {16'd0, max_arguments})
                                err = lprd_pkg::ERR_MALFORM;
                            else
                            begin
                                ns.args_rem   = v[15:0];
                                ns.total_args = v[15:0];
                                ns.cur_arg    = '0;
                                sect          = 1'b1;
                            end
                        end
                        default:
                        begin
                            // argument length header
                            if (v > {8'd0, ns.body_rem})
                                err = lprd_pkg::ERR_MALFORM;
                            else
                            begin
                                ns.arg_bytes_rem = v[23:0];
                                if (state.cur_arg == '0 && v != 32'd3)
                                    ns.match = 3'b000;
                                if (v == '0)
                                    fin = 1'b1;
                                else
                                    ns.phase = lprd_pkg::PH_DATA;
                            end
                        end
                    endcase
                end
            end

            if (fin)
            begin
                r.arg_index = state.cur_arg;
                r.arg_end   = 1'b1;
                ns.args_rem = ns.args_rem - 16'd1;
                ns.cur_arg  = state.cur_arg + 16'd1;
                sect        = 1'b1;
            end

            if (sect)
            begin
                if (ns.args_rem == '0)
                begin
                    if (ns.body_rem == '0)
                    begin
                        r.frame_done = 1'b1;
                        r.arg_count  = ns.total_args;
                        r.command    = classify(ns.total_args, ns.match);
                        ns.phase     = lprd_pkg::PH_LEN;
                    end
                    else
                        err = lprd_pkg::ERR_MALFORM;  // trailing bytes
                end
                else if (ns.body_rem < 24'd4)
                    err = lprd_pkg::ERR_MALFORM;      // no room for next arg header
                else
                    ns.phase = lprd_pkg::PH_ARGLEN;
            end

            if (err != lprd_pkg::ERR_NONE)
            begin
                ns.halt      = 1'b1;
                r.error_code = err;
                r.halted     = 1'b1;
            end
        end

        state_next = ns;
        result     = r;
    end

endmodule

`default_nettype wire

### rtl/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer: channels, config
// registers, parser state and result register. Uses lprd_pkg and lprd_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | sink      | in_valid/in_stall  | in_byte
//  out     | source    | out_valid/out_stall| data_valid .. halted (9 fields)
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input byte per cycle while in_stall is low; each result is registered as its byte is taken.
// The parser state update is the feedback loop, compare/decrement of a 24-bit count.
// in_stall rises only while a result sits unread under out_stall.
// Reset: parser waits for a body length header, limits return to 4096 / 1024.
// cfg writes are always ready.
`default_nettype none

module length_prefixed_request_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    in_byte,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               data_valid,
    output logic [7:0]                         data_byte,
    output logic [lprd_pkg::ARG_W-1:0]         arg_index,
    output logic                               arg_end,
    output logic                               frame_done,
    output logic [lprd_pkg::ARG_W-1:0]         arg_count,
    output logic [1:0]                         command,
    output logic [1:0]                         error_code,
    output logic                               halted,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [lprd_pkg::BODY_W-1:0]   cfg_data
);

    lprd_pkg::state_t              state_reg;
    lprd_pkg::state_t              state_next;
    lprd_pkg::result_t             result_reg;
    lprd_pkg::result_t             result_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [lprd_pkg::BODY_W-1:0]   max_body_reg;
    logic [lprd_pkg::ARG_W-1:0]    max_args_reg;
    logic                          in_take;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    lprd_step u_step (
        .in_byte         (in_byte),
        .state           (state_reg),
        .max_body_length (max_body_reg),
        .max_arguments   (max_args_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    always_comb
    begin
        if (in_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lprd_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
            max_body_reg  <= lprd_pkg::MAX_BODY_RESET;
            max_args_reg  <= lprd_pkg::MAX_ARGS_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_take)
                state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    lprd_pkg::CFG_MAX_BODY: max_body_reg <= cfg_data;
                    lprd_pkg::CFG_MAX_ARGS: max_args_reg <= cfg_data[lprd_pkg::ARG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign data_valid = result_reg.data_valid;
    assign data_byte  = result_reg.data_byte;
    assign arg_index  = result_reg.arg_index;
    assign arg_end    = result_reg.arg_end;
    assign frame_done = result_reg.frame_done;
    assign arg_count  = result_reg.arg_count;
    assign command    = result_reg.command;
    assign error_code = result_reg.error_code;
    assign halted     = result_reg.halted;

endmodule

`default_nettype wire

### sim/length_prefixed_request_deframer_tb.sv
// Testbench for length_prefixed_request_deframer: streams framed requests, tracks the
// parser in a local predictor and checks every result field by field.
// Depends on lprd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module length_prefixed_request_deframer_tb;

    localparam int HEADER_BYTES = 4;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 100;

    // first-argument selectors beyond the three command names (M_GET, M_SET, M_DEL)
    localparam int NAME_NEAR  = 3;
    localparam int NAME_OTHER = 4;

    typedef enum int {
        F_TOO_LONG, F_SHORT_BODY, F_TOO_MANY_ARGS, F_NO_ARG_HEADER, F_OVERRUN, F_TRAILING
    } fault_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [7:0]                    in_byte   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          data_valid;
    logic [7:0]                    data_byte;
    logic [lprd_pkg::ARG_W-1:0]    arg_index;
    logic                          arg_end;
    logic                          frame_done;
    logic [lprd_pkg::ARG_W-1:0]    arg_count;
    logic [1:0]                    command;
    logic [1:0]                    error_code;
    logic                          halted;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = lprd_pkg::CFG_MAX_BODY;
    logic [lprd_pkg::BODY_W-1:0]   cfg_data  = '0;

    length_prefixed_request_deframer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .arg_index  (arg_index),
        .arg_end    (arg_end),
        .frame_done (frame_done),
        .arg_count  (arg_count),
        .command    (command),
        .error_code (error_code),
        .halted     (halted),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predicted parser state and limits
    lprd_pkg::phase_t              p_phase      = lprd_pkg::PH_LEN;
    logic [1:0]                    p_hdr_cnt    = '0;
    logic [31:0]                   p_hdr_word   = '0;
    logic [lprd_pkg::BODY_W-1:0]   p_body_left  = '0;
    logic [lprd_pkg::ARG_W-1:0]    p_args_left  = '0;
    logic [lprd_pkg::BODY_W-1:0]   p_bytes_left = '0;
    logic [lprd_pkg::ARG_W-1:0]    p_arg_num    = '0;
    logic [lprd_pkg::ARG_W-1:0]    p_arg_total  = '0;
    logic [2:0]                    p_name_ok    = 3'b111;
    logic                          p_halted     = 1'b0;
    logic [lprd_pkg::BODY_W-1:0]   lim_body     = lprd_pkg::MAX_BODY_RESET;
    logic [lprd_pkg::ARG_W-1:0]    lim_args     = lprd_pkg::MAX_ARGS_RESET;
    lprd_pkg::result_t             step_res;

    lprd_pkg::result_t             awaited_results[$];
    logic [7:0]                    req_body[$];

    int bytes_taken   = 0;
    int regs_written  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int stuck_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    //------------------------------------------------------------------
    // predictor
    //------------------------------------------------------------------
    function automatic logic [7:0] name_char(input int k, input int pos);
        logic [23:0] w;
        case (k)
            lprd_pkg::M_GET: w = "get";
            lprd_pkg::M_SET: w = "set";
            default:         w = "del";
        endcase
        return w[23 - 8*pos -: 8];
    endfunction

    task automatic flag_error(input lprd_pkg::err_t code);
        p_halted = 1'b1;
        step_res.error_code = code;
        step_res.halted = 1'b1;
    endtask

    task automatic end_section();
        p_hdr_cnt  = '0;
        p_hdr_word = '0;
        if (p_args_left == 0) begin
            if (p_body_left == 0) begin
                step_res.frame_done = 1'b1;
                step_res.arg_count  = p_arg_total;
                if (p_arg_total == 2 && p_name_ok[lprd_pkg::M_GET])
                    step_res.command = lprd_pkg::CMD_GET;
                else if (p_arg_total == 3 && p_name_ok[lprd_pkg::M_SET])
                    step_res.command = lprd_pkg::CMD_SET;
                else if (p_arg_total == 2 && p_name_ok[lprd_pkg::M_DEL])
                    step_res.command = lprd_pkg::CMD_DEL;
                else
                    step_res.command = lprd_pkg::CMD_UNKNOWN;
                p_phase = lprd_pkg::PH_LEN;
            end
            else
            begin
                flag_error(lprd_pkg::ERR_MALFORM);   // body bytes left after the last argument
            end
        end
        else if (p_body_left < HEADER_BYTES) begin
            flag_error(lprd_pkg::ERR_MALFORM);       // no room for the next argument header
        end
        else
        begin
            p_phase = lprd_pkg::PH_ARGLEN;
        end
    endtask

    task automatic end_argument();
        step_res.arg_index = p_arg_num;
        step_res.arg_end   = 1'b1;
        p_args_left--;
        p_arg_num++;
        end_section();
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0]  lc;
        logic [31:0] v;
        int          k;
        step_res = '0;
        if (p_halted) begin
            step_res.halted = 1'b1;
        end
        else
        begin
            if (p_phase != lprd_pkg::PH_LEN)
                p_body_left--;
            if (p_phase == lprd_pkg::PH_DATA) begin
                lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                step_res.data_valid = 1'b1;
                step_res.data_byte  = b;
                step_res.arg_index  = p_arg_num;
                if (p_arg_num == 0 && p_name_ok != 0 && p_bytes_left >= 1 && p_bytes_left <= 3)
                begin
                    for (k = 0; k < 3; k++)
                        if (name_char(k, 3 - p_bytes_left) != lc)
                            p_name_ok[k] = 1'b0;
                end
                p_bytes_left--;
                if (p_bytes_left == 0)
                    end_argument();
            end
            else
            begin
                p_hdr_word = {b, p_hdr_word[31:8]};
                if (p_hdr_cnt != 2'd3) begin
                    p_hdr_cnt++;
                end
                else
                begin
                    v = p_hdr_word;
                    p_hdr_cnt  = '0;
                    p_hdr_word = '0;
                    case (p_phase)
                        lprd_pkg::PH_LEN: begin
                            if (v > lim_body)
                                flag_error(lprd_pkg::ERR_TOO_LONG);
                            else if (v < HEADER_BYTES)
                                flag_error(lprd_pkg::ERR_MALFORM);
                            else
                            begin
                                p_body_left = v[lprd_pkg::BODY_W-1:0];
                                p_name_ok   = 3'b111;
                                p_phase     = lprd_pkg::PH_ARGC;
                            end
                        end
                        lprd_pkg::PH_ARGC: begin
                            if (v > lim_args)
                                flag_error(lprd_pkg::ERR_MALFORM);
                            else
                            begin
                                p_args_left = v[lprd_pkg::ARG_W-1:0];
                                p_arg_total = v[lprd_pkg::ARG_W-1:0];
                                p_arg_num   = '0;
                                end_section();
                            end
                        end
                        default: begin
                            if (v > p_body_left)
                                flag_error(lprd_pkg::ERR_MALFORM);
                            else
                            begin
                                p_bytes_left = v[lprd_pkg::BODY_W-1:0];
                                // only a three-byte first argument can name a command
                                if (p_arg_num == 0 && v != 3)
                                    p_name_ok = '0;
                                if (v == 0)
                                    end_argument();
                                else
                                    p_phase = lprd_pkg::PH_DATA;
                            end
                        end
                    endcase
                end
            end
        end
    endtask

    //------------------------------------------------------------------
    // checking
    //------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want)
            report_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                                      results_seen, name, want, seen));
    endtask

    always @(posedge clk) begin : monitor
        lprd_pkg::result_t want;
        logic              took_any;
        took_any = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                took_any = 1'b1;
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              results_seen));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("data_valid", 16'(want.data_valid), 16'(data_valid));
                    check_field("data_byte",  16'(want.data_byte),  16'(data_byte));
                    check_field("arg_index",  want.arg_index,       arg_index);
                    check_field("arg_end",    16'(want.arg_end),    16'(arg_end));
                    check_field("frame_done", 16'(want.frame_done), 16'(frame_done));
                    check_field("arg_count",  want.arg_count,       arg_count);
                    check_field("command",    16'(want.command),    16'(command));
                    check_field("error_code", 16'(want.error_code), 16'(error_code));
                    check_field("halted",     16'(want.halted),     16'(halted));
                end
            end
            if (in_valid && !in_stall) begin
                took_any = 1'b1;
                deframe_byte(in_byte);
                awaited_results = {awaited_results, step_res};
                bytes_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                took_any = 1'b1;
                if (cfg_index == lprd_pkg::CFG_MAX_BODY)
                    lim_body = cfg_data;
                else
                    lim_args = cfg_data[lprd_pkg::ARG_W-1:0];
                regs_written++;
            end
            if (took_any)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    //------------------------------------------------------------------
    // stimulus
    //------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int target;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        target = bytes_taken + 1;
        do @(negedge clk); while (bytes_taken != target);
    endtask

    task automatic send_word(input logic [31:0] w);
        int i;
        for (i = 0; i < HEADER_BYTES; i++)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_framed();
        send_word(32'(req_body.size()));
        foreach (req_body[j])
            send_byte(req_body[j]);
    endtask

    // fill < 0 gives random content, else every data byte outside the command name is fill
    task automatic build_request(input int n_args, input int name_sel, input int len_cap,
                                 input int fill);
        logic [31:0] w;
        logic [7:0]  c;
        int          a, i, alen, spot, base;
        req_body = {};
        spot = $urandom_range(2);
        base = $urandom_range(2);
        w = n_args;
        for (i = 0; i < HEADER_BYTES; i++)
            req_body = {req_body, w[8*i +: 8]};
        for (a = 0; a < n_args; a++) begin
            alen = (a == 0 && name_sel != NAME_OTHER) ? 3 : $urandom_range(len_cap);
            w = alen;
            for (i = 0; i < HEADER_BYTES; i++)
                req_body = {req_body, w[8*i +: 8]};
            for (i = 0; i < alen; i++) begin
                c = (fill >= 0) ? fill[7:0] : 8'($urandom_range(255));
                if (a == 0 && name_sel != NAME_OTHER && (name_sel != NAME_NEAR || i != spot))
                begin
                    c = name_char((name_sel == NAME_NEAR) ? base : name_sel, i);
                    if ($urandom_range(1))
                        c = c - 8'd32;
                end
                req_body = {req_body, c};
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited_results.size() != 0);
    endtask

    // only called with the parser idle between requests
    task automatic set_limits(input logic [lprd_pkg::BODY_W-1:0] body,
                              input logic [lprd_pkg::ARG_W-1:0] args);
        logic [7:0] pad;
        int         i, target;
        pad = 8'($urandom_range(255));
        for (i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? lprd_pkg::CFG_MAX_BODY : lprd_pkg::CFG_MAX_ARGS;
            cfg_data  <= (i == 0) ? body : {pad, args};
            target = regs_written + 1;
            do @(negedge clk); while (regs_written != target);
        end
        cfg_valid <= 1'b0;
    endtask

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------
    task automatic test_commands();
        build_request(2, lprd_pkg::M_GET, 4, -1);  send_framed();
        build_request(3, lprd_pkg::M_SET, 4, -1);  send_framed();
        build_request(2, lprd_pkg::M_DEL, 4, -1);  send_framed();
        build_request(3, lprd_pkg::M_GET, 2, -1);  send_framed();  // wrong arity
        build_request(2, lprd_pkg::M_SET, 2, -1);  send_framed();
        build_request(2, NAME_NEAR, 3, -1);        send_framed();
        build_request(2, NAME_OTHER, 0, -1);       send_framed();  // empty arguments
        build_request(0, NAME_OTHER, 0, -1);       send_framed();  // bare count
        build_request(1, NAME_OTHER, 6, 8'h00);    send_framed();
        build_request(1, NAME_OTHER, 6, 8'hFF);    send_framed();
    endtask

    task automatic test_limit_edges();
        drain();
        set_limits(24'(HEADER_BYTES), 16'd0);
        repeat (3) begin
            build_request(0, NAME_OTHER, 0, -1);
            send_framed();
        end
        build_request(2, lprd_pkg::M_GET, 9, -1);
        drain();
        set_limits(24'(req_body.size()), 16'd2);
        send_framed();
        build_request(3, lprd_pkg::M_SET, 9, -1);
        drain();
        set_limits(24'(req_body.size()), 16'd3);
        send_framed();
    endtask

    task automatic test_random_traffic();
        int ph, stop_at, r, n, sel, cap;
        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 53; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            if (ph == 0)
                set_limits({lprd_pkg::BODY_W{1'b1}}, {lprd_pkg::ARG_W{1'b1}});
            else
                set_limits(24'($urandom_range(400, 24'hFFFFFF)),
                           16'($urandom_range(12, 16'hFFFF)));
            stop_at = bytes_taken + 160;
            while (bytes_taken < stop_at) begin
                r   = $urandom_range(9);
                n   = (r < 4) ? 2 : (r < 6) ? 3 : (r == 6) ? 0 : (r == 7) ? 1
                    : $urandom_range(4, 12);
                sel = $urandom_range(5);
                if (sel > NAME_OTHER)
                    sel = NAME_OTHER;
                cap = ($urandom_range(3) == 0) ? 24 : 6;
                build_request(n, sel, cap, -1);
                send_framed();
            end
        end
    endtask

    // any error halts the parser for good, so one fault per run, then ignored noise
    task automatic test_fatal_error();
        fault_t      fault;
        logic [31:0] w;
        int          k;
        fault = fault_t'($urandom_range(5));
        case (fault)
            F_TOO_LONG: begin
                w = $urandom;
                if (w <= lim_body)
                    w = lim_body + 1;
                send_word(w);
            end
            F_SHORT_BODY: begin
                send_word($urandom_range(HEADER_BYTES - 1));
            end
            F_TOO_MANY_ARGS: begin
                send_word(2 * HEADER_BYTES);
                w = $urandom;
                if (w <= lim_args)
                    w = lim_args + 1;
                send_word(w);
            end
            F_NO_ARG_HEADER: begin
                send_word(HEADER_BYTES + $urandom_range(1, HEADER_BYTES - 1));
                send_word($urandom_range(1, lim_args));
            end
            F_OVERRUN: begin
                k = $urandom_range(10);
                send_word(2 * HEADER_BYTES + k);
                send_word(1);
                w = $urandom;
                if (w <= k)
                    w = k + 1;
                send_word(w);
            end
            default: begin
                send_word(HEADER_BYTES + $urandom_range(1, 12));
                send_word(0);
            end
        endcase
        repeat (16)
            send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_commands();
        test_limit_edges();
        test_random_traffic();
        test_fatal_error();
        drain();
        stall_pct = 0;
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
